// ----- sv/qrrs_pkg.sv -----
`default_nettype none

package qrrs_pkg;

  localparam int EPS_BITS = 31;
  localparam logic [EPS_BITS-1:0] EPS_RESET = 31'd1;

  localparam logic [1:0] ROOTS_NONE = 2'd0;
  localparam logic [1:0] ROOTS_ONE  = 2'd1;
  localparam logic [1:0] ROOTS_TWO  = 2'd2;

endpackage

`default_nettype wire

// ----- sv/quadratic_real_root_solver.sv -----
// Real roots of c + b*x + a*x^2, coefficients and roots signed fixed point
// (WORD_BITS wide, FRAC_BITS fraction bits).
// Input channel: in_valid / in_stall with coef_const, coef_linear, coef_square.
// Output channel: out_valid / out_stall with root_first, root_second,
// root_count and saturated; exactly one result item per input item, in order.
// Threshold eps is written through cfg_wr_en / cfg_wr_data; the user
// must write it only while idle, as the block does not enforce this.
// The pipeline has four front stages (magnitudes, products, discriminant,
// classify), one stage per square root bit, one operand stage, one stage
// per quotient bit of the two parallel dividers, and the output register.
// Throughput is one item per cycle unless the output stalls. When out_valid
// is high and out_stall is high the whole pipeline holds and in_stall rises
// in the same cycle; no item is lost or repeated.
// Synchronous reset clears all valid bits and sets eps to 1.
`default_nettype none

module quadratic_real_root_solver #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_wr_en,
  input  wire logic [qrrs_pkg::EPS_BITS-1:0] cfg_wr_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic signed [WORD_BITS-1:0] coef_const,
  input  wire logic signed [WORD_BITS-1:0] coef_linear,
  input  wire logic signed [WORD_BITS-1:0] coef_square,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic signed [WORD_BITS-1:0]      root_first,
  output logic signed [WORD_BITS-1:0]      root_second,
  output logic [1:0]                       root_count,
  output logic                             saturated
);

  localparam int W    = WORD_BITS;
  localparam int EW   = qrrs_pkg::EPS_BITS;
  localparam int PW   = 2 * W;
  localparam int DW   = 2 * W + 2;
  localparam int RW   = W + 1;
  localparam int NUMW = W + 1;
  localparam int NW   = W + 1 + FRAC_BITS;
  localparam int DVW  = W + 1;
  localparam int CMPW = (W > EW) ? W : EW;
  localparam int DCW  = (DW > 2 * EW) ? DW : 2 * EW;
  localparam int SQSW = 3 * W + 6;
  localparam int SAW  = 6;
  localparam int SBW  = 3;

  logic en;
  logic [EW-1:0] eps;

  assign en       = !(out_valid && out_stall);
  assign in_stall = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      eps <= qrrs_pkg::EPS_RESET;
    end else if (cfg_wr_en) begin
      eps <= cfg_wr_data;
    end
  end

  // stage 1: magnitudes and signs
  logic         v1;
  logic [W-1:0] amag1, bmag1, cmag1;
  logic         aneg1, bneg1, cneg1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      aneg1 <= coef_square[W-1];
      bneg1 <= coef_linear[W-1];
      cneg1 <= coef_const[W-1];
      amag1 <= coef_square[W-1] ? W'(~$unsigned(coef_square) + 1'b1) : $unsigned(coef_square);
      bmag1 <= coef_linear[W-1] ? W'(~$unsigned(coef_linear) + 1'b1) : $unsigned(coef_linear);
      cmag1 <= coef_const[W-1]  ? W'(~$unsigned(coef_const) + 1'b1)  : $unsigned(coef_const);
    end
  end

  // stage 2: products and threshold tests
  logic          v2;
  logic [PW-1:0] b2_2, ac_2;
  logic [2*EW-1:0] e2_2;
  logic [W-1:0]  amag2, bmag2, cmag2;
  logic          aneg2, bneg2, cneg2, acn2, aok2, bok2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b2_2  <= PW'(bmag1) * PW'(bmag1);
      ac_2  <= PW'(amag1) * PW'(cmag1);
      e2_2  <= (2*EW)'(eps) * (2*EW)'(eps);
      aok2  <= CMPW'(amag1) >= CMPW'(eps);
      bok2  <= CMPW'(bmag1) >= CMPW'(eps);
      acn2  <= (aneg1 != cneg1) && (amag1 != '0) && (cmag1 != '0);
      amag2 <= amag1;
      bmag2 <= bmag1;
      cmag2 <= cmag1;
      aneg2 <= aneg1;
      bneg2 <= bneg1;
      cneg2 <= cneg1;
    end
  end

  // stage 3: discriminant
  logic          v3;
  logic [DW-1:0] d3;
  logic          dneg3;
  logic [2*EW-1:0] e2_3;
  logic [W-1:0]  amag3, bmag3, cmag3;
  logic          aneg3, bneg3, cneg3, aok3, bok3;
  logic [DW-1:0] t_c, b2x_c;

  assign t_c   = {ac_2, 2'b00};
  assign b2x_c = DW'(b2_2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (acn2) begin
        d3    <= b2x_c + t_c;
        dneg3 <= 1'b0;
      end else if (b2x_c >= t_c) begin
        d3    <= b2x_c - t_c;
        dneg3 <= 1'b0;
      end else begin
        d3    <= '0;
        dneg3 <= 1'b1;
      end
      e2_3  <= e2_2;
      aok3  <= aok2;
      bok3  <= bok2;
      amag3 <= amag2;
      bmag3 <= bmag2;
      cmag3 <= cmag2;
      aneg3 <= aneg2;
      bneg3 <= bneg2;
      cneg3 <= cneg2;
    end
  end

  // stage 4: classify
  logic          v4;
  logic [DW-1:0] d4;
  logic          two4, one4, lin4;
  logic [W-1:0]  amag4, bmag4, cmag4;
  logic          aneg4, bneg4, cneg4;
  logic          dge_c;

  assign dge_c = DCW'(d3) >= DCW'(e2_3);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d4    <= d3;
      two4  <= aok3 && !dneg3 && dge_c;
      one4  <= aok3 && !dneg3 && !dge_c;
      lin4  <= !aok3 && bok3;
      amag4 <= amag3;
      bmag4 <= bmag3;
      cmag4 <= cmag3;
      aneg4 <= aneg3;
      bneg4 <= bneg3;
      cneg4 <= cneg3;
    end
  end

  // square root
  logic            vs;
  logic [RW-1:0]   s_root;
  logic [SQSW-1:0] sq_side_in, sq_side_out;
  logic [W-1:0]    amag_s, bmag_s, cmag_s;
  logic            aneg_s, bneg_s, cneg_s, two_s, one_s, lin_s;

  assign sq_side_in = {amag4, bmag4, cmag4, aneg4, bneg4, cneg4, two4, one4, lin4};
  assign {amag_s, bmag_s, cmag_s, aneg_s, bneg_s, cneg_s, two_s, one_s, lin_s} = sq_side_out;

  qrrs_sqrt #(
    .DW (DW),
    .SW (SQSW)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v4),
    .in_d      (d4),
    .in_side   (sq_side_in),
    .out_valid (vs),
    .out_root  (s_root),
    .out_side  (sq_side_out)
  );

  // stage 5: divider operands
  logic            v5;
  logic [NUMW-1:0] num_a5, num_b5;
  logic [DVW-1:0]  den_a5, den_b5;
  logic [SAW-1:0]  side_a5;
  logic [SBW-1:0]  side_b5;
  logic [NUMW-1:0] qmag_c;
  logic            bpos_c, cpos_c, nneg_a_c, dneg_a_c;
  logic [DVW-1:0]  den_a_c;

  assign qmag_c   = {1'b0, bmag_s} + s_root;
  assign bpos_c   = !bneg_s && (bmag_s != '0);
  assign cpos_c   = !cneg_s && (cmag_s != '0);
  assign nneg_a_c = lin_s ? cpos_c : bpos_c;
  assign dneg_a_c = lin_s ? bneg_s : aneg_s;
  assign den_a_c  = lin_s ? {1'b0, bmag_s} : {amag_s, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= vs;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_a5  <= two_s ? qmag_c : (one_s ? {1'b0, bmag_s} : {1'b0, cmag_s});
      den_a5  <= den_a_c;
      side_a5 <= {two_s, one_s, lin_s, nneg_a_c, nneg_a_c != dneg_a_c, den_a_c == '0};
      num_b5  <= {cmag_s, 1'b0};
      den_b5  <= qmag_c;
      side_b5 <= {cneg_s, cneg_s != bpos_c, qmag_c == '0};
    end
  end

  // dividers
  logic           vd, vd_b;
  logic [NW-1:0]  quo_a, quo_b;
  logic [SAW-1:0] side_a;
  logic [SBW-1:0] side_b;

  qrrs_div #(
    .NW  (NW),
    .DVW (DVW),
    .SW  (SAW)
  ) u_div_a (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v5),
    .in_num    ({num_a5, {FRAC_BITS{1'b0}}}),
    .in_den    (den_a5),
    .in_side   (side_a5),
    .out_valid (vd),
    .out_quo   (quo_a),
    .out_side  (side_a)
  );

  qrrs_div #(
    .NW  (NW),
    .DVW (DVW),
    .SW  (SBW)
  ) u_div_b (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v5),
    .in_num    ({num_b5, {FRAC_BITS{1'b0}}}),
    .in_den    (den_b5),
    .in_side   (side_b5),
    .out_valid (vd_b),
    .out_quo   (quo_b),
    .out_side  (side_b)
  );

  // output stage
  function automatic logic [W:0] fix_quo(input logic [NW-1:0] q, input logic nneg,
                                         input logic neg, input logic zero);
    logic [NW-1:0] negmag;
    logic [NW-1:0] posmax;
    logic [W:0]    res;
    negmag = NW'(1) << (W - 1);
    posmax = negmag - 1'b1;
    if (zero) begin
      res = {1'b1, nneg ? negmag[W-1:0] : posmax[W-1:0]};
    end else if (neg) begin
      if (q > negmag) begin
        res = {1'b1, negmag[W-1:0]};
      end else begin
        res = {1'b0, W'(~q[W-1:0] + 1'b1)};
      end
    end else if (q > posmax) begin
      res = {1'b1, posmax[W-1:0]};
    end else begin
      res = {1'b0, q[W-1:0]};
    end
    return res;
  endfunction

  logic [W:0] res_a, res_b;
  logic       two_o, one_o, lin_o, nneg_a_o;

  assign res_a = fix_quo(quo_a, side_a[2], side_a[1], side_a[0]);
  assign res_b = fix_quo(quo_b, side_b[2], side_b[1], side_b[0]);
  assign {two_o, one_o, lin_o, nneg_a_o} = side_a[5:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vd && vd_b;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (two_o) begin
        root_first  <= nneg_a_o ? res_b[W-1:0] : res_a[W-1:0];
        root_second <= nneg_a_o ? res_a[W-1:0] : res_b[W-1:0];
        root_count  <= qrrs_pkg::ROOTS_TWO;
        saturated   <= res_a[W] || res_b[W];
      end else if (one_o || lin_o) begin
        root_first  <= res_a[W-1:0];
        root_second <= '0;
        root_count  <= qrrs_pkg::ROOTS_ONE;
        saturated   <= res_a[W];
      end else begin
        root_first  <= '0;
        root_second <= '0;
        root_count  <= qrrs_pkg::ROOTS_NONE;
        saturated   <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/qrrs_sqrt.sv -----
`default_nettype none

module qrrs_sqrt #(
  parameter int DW = 66,
  parameter int SW = 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [DW-1:0]     in_d,
  input  wire logic [SW-1:0]     in_side,
  output logic                   out_valid,
  output logic [DW/2-1:0]        out_root,
  output logic [SW-1:0]          out_side
);

  localparam int RW = DW / 2;
  localparam int MW = RW + 2;

  logic [MW-1:0] rem_q  [RW-1];
  logic [RW-1:0] root_q [RW];
  logic [DW-1:0] d_q    [RW-1];
  logic [SW-1:0] side_q [RW];
  logic [RW-1:0] vld_q;

  genvar k;
  generate
    for (k = 0; k < RW; k++) begin : g_stage
      logic [MW-1:0] prem;
      logic [RW-1:0] proot;
      logic [DW-1:0] pd;
      logic [SW-1:0] pside;
      logic          pv;
      logic [MW+1:0] cur;
      logic [MW+1:0] trial;
      logic [MW+1:0] diff;
      logic          ge;

      if (k == 0) begin : g_first
        assign prem  = '0;
        assign proot = '0;
        assign pd    = in_d;
        assign pside = in_side;
        assign pv    = in_valid;
      end else begin : g_next
        assign prem  = rem_q[k-1];
        assign proot = root_q[k-1];
        assign pd    = d_q[k-1];
        assign pside = side_q[k-1];
        assign pv    = vld_q[k-1];
      end

      assign cur   = {prem, pd[DW-1 -: 2]};
      assign trial = {2'b00, proot, 2'b01};
      assign ge    = cur >= trial;
      assign diff  = cur - trial;

      always_ff @(posedge clk) begin
        if (rst) begin
          vld_q[k] <= 1'b0;
        end else if (en) begin
          vld_q[k] <= pv;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          root_q[k] <= {proot[RW-2:0], ge};
          side_q[k] <= pside;
        end
      end

      if (k < RW - 1) begin : g_shift
        always_ff @(posedge clk) begin
          if (en) begin
            rem_q[k] <= ge ? diff[MW-1:0] : cur[MW-1:0];
            d_q[k]   <= pd << 2;
          end
        end
      end
    end
  endgenerate

  assign out_valid = vld_q[RW-1];
  assign out_root  = root_q[RW-1];
  assign out_side  = side_q[RW-1];

endmodule

`default_nettype wire

// ----- sv/qrrs_div.sv -----
`default_nettype none

module qrrs_div #(
  parameter int NW  = 49,
  parameter int DVW = 33,
  parameter int SW  = 1
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire logic [NW-1:0]   in_num,
  input  wire logic [DVW-1:0]  in_den,
  input  wire logic [SW-1:0]   in_side,
  output logic                 out_valid,
  output logic [NW-1:0]        out_quo,
  output logic [SW-1:0]        out_side
);

  logic [DVW-1:0] rem_q  [NW-1];
  logic [NW-1:0]  quo_q  [NW];
  logic [NW-1:0]  num_q  [NW-1];
  logic [DVW-1:0] den_q  [NW-1];
  logic [SW-1:0]  side_q [NW];
  logic [NW-1:0]  vld_q;

  genvar k;
  generate
    for (k = 0; k < NW; k++) begin : g_stage
      logic [DVW-1:0] prem;
      logic [NW-1:0]  pquo;
      logic [NW-1:0]  pnum;
      logic [DVW-1:0] pden;
      logic [SW-1:0]  pside;
      logic           pv;
      logic [DVW:0]   cur;
      logic [DVW:0]   diff;
      logic           ge;

      if (k == 0) begin : g_first
        assign prem  = '0;
        assign pquo  = '0;
        assign pnum  = in_num;
        assign pden  = in_den;
        assign pside = in_side;
        assign pv    = in_valid;
      end else begin : g_next
        assign prem  = rem_q[k-1];
        assign pquo  = quo_q[k-1];
        assign pnum  = num_q[k-1];
        assign pden  = den_q[k-1];
        assign pside = side_q[k-1];
        assign pv    = vld_q[k-1];
      end

      assign cur  = {prem, pnum[NW-1]};
      assign ge   = cur >= {1'b0, pden};
      assign diff = cur - {1'b0, pden};

      always_ff @(posedge clk) begin
        if (rst) begin
          vld_q[k] <= 1'b0;
        end else if (en) begin
          vld_q[k] <= pv;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          quo_q[k]  <= {pquo[NW-2:0], ge};
          side_q[k] <= pside;
        end
      end

      if (k < NW - 1) begin : g_carry
        always_ff @(posedge clk) begin
          if (en) begin
            rem_q[k] <= ge ? diff[DVW-1:0] : cur[DVW-1:0];
            num_q[k] <= pnum << 1;
            den_q[k] <= pden;
          end
        end
      end
    end
  endgenerate

  assign out_valid = vld_q[NW-1];
  assign out_quo   = quo_q[NW-1];
  assign out_side  = side_q[NW-1];

endmodule

`default_nettype wire

// ----- dv/tb_quadratic_real_root_solver.sv -----
`default_nettype none

typedef struct packed {
  logic [31:0] root_first;
  logic [31:0] root_second;
  logic [1:0]  root_count;
  logic        saturated;
} root_set_t;

class root_scoreboard;
  localparam logic [63:0] POS_LIMIT = 64'h7fff_ffff;
  localparam logic [63:0] NEG_LIMIT = 64'h8000_0000;

  logic [30:0] eps;
  root_set_t   pending[$];
  int          errors;

  function new();
    eps = qrrs_pkg::EPS_RESET;
    errors = 0;
  endfunction

  function void report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    if (errors <= 30)
      $display("MISMATCH %s: got %h expected %h", what, got, want);
  endfunction

  function void split(logic [31:0] raw, output logic [63:0] mag, output bit neg);
    neg = raw[31];
    mag = neg ? {32'd0, -raw} : {32'd0, raw};
  endfunction

  function logic [31:0] fixed_quotient(logic [63:0] nm, bit nn, logic [63:0] dm, bit dn,
                                       inout bit sat);
    logic [127:0] q;
    if (dm == 0) begin
      sat = 1;
      return nn ? NEG_LIMIT[31:0] : POS_LIMIT[31:0];
    end
    q = ({64'd0, nm} << 16) / {64'd0, dm};
    if (nn != dn) begin
      if (q > {64'd0, NEG_LIMIT}) begin
        sat = 1;
        return NEG_LIMIT[31:0];
      end
      return -q[31:0];
    end
    if (q > {64'd0, POS_LIMIT}) begin
      sat = 1;
      return POS_LIMIT[31:0];
    end
    return q[31:0];
  endfunction

  function logic [63:0] floor_sqrt(logic [127:0] d);
    logic [63:0] res;
    logic [63:0] cand;
    res = 0;
    for (int i = 63; i >= 0; i--) begin
      cand = res | (64'd1 << i);
      if (d >= {64'd0, cand} * {64'd0, cand}) res = cand;
    end
    return res;
  endfunction

  function void note_input(logic [31:0] c, logic [31:0] b, logic [31:0] a);
    logic [63:0] cm, bm, am, s, qm, via_a, via_c;
    logic [127:0] b2, t, e2, d;
    bit cn, bn, an, sat, dneg, bpos;
    root_set_t r;
    split(c, cm, cn);
    split(b, bm, bn);
    split(a, am, an);
    sat = 0;
    r = '0;
    r.root_count = qrrs_pkg::ROOTS_NONE;
    if (am >= {33'd0, eps}) begin
      b2 = {64'd0, bm} * {64'd0, bm};
      t = ({64'd0, am} * {64'd0, cm}) << 2;
      e2 = {97'd0, eps} * {97'd0, eps};
      dneg = 0;
      if (an != cn && am != 0 && cm != 0) d = b2 + t;
      else if (b2 >= t) d = b2 - t;
      else begin
        dneg = 1;
        d = t - b2;
      end
      if (!dneg && d >= e2) begin
        s = floor_sqrt(d);
        qm = bm + s;
        bpos = !bn && bm != 0;
        via_a = {32'd0, fixed_quotient(qm, bpos, am << 1, an, sat)};
        via_c = {32'd0, fixed_quotient(cm << 1, cn, qm, bpos, sat)};
        r.root_first = bpos ? via_c[31:0] : via_a[31:0];
        r.root_second = bpos ? via_a[31:0] : via_c[31:0];
        r.root_count = qrrs_pkg::ROOTS_TWO;
      end else if (!dneg) begin
        r.root_first = fixed_quotient(bm, !bn && bm != 0, am << 1, an, sat);
        r.root_count = qrrs_pkg::ROOTS_ONE;
      end
    end else if (bm >= {33'd0, eps}) begin
      r.root_first = fixed_quotient(cm, !cn && cm != 0, bm, bn, sat);
      r.root_count = qrrs_pkg::ROOTS_ONE;
    end
    r.saturated = sat;
    pending = {pending, r};
  endfunction

  function void check_result(root_set_t got);
    root_set_t want;
    if (pending.size() == 0) begin
      report("unexpected result item", got.root_first, 32'd0);
      return;
    end
    want = pending.pop_front();
    if (got.root_first !== want.root_first) report("root_first", got.root_first, want.root_first);
    if (got.root_second !== want.root_second)
      report("root_second", got.root_second, want.root_second);
    if (got.root_count !== want.root_count)
      report("root_count", {30'd0, got.root_count}, {30'd0, want.root_count});
    if (got.saturated !== want.saturated)
      report("saturated", {31'd0, got.saturated}, {31'd0, want.saturated});
  endfunction
endclass

module tb_quadratic_real_root_solver;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0;
  logic rst = 1;
  logic cfg_wr_en = 0;
  logic [qrrs_pkg::EPS_BITS-1:0] cfg_wr_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [31:0] coef_const = '0;
  logic signed [31:0] coef_linear = '0;
  logic signed [31:0] coef_square = '0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [31:0] root_first, root_second;
  logic [1:0] root_count;
  logic saturated;

  root_scoreboard sb = new();
  int hold_cycles = 0;
  bit hold_req = 0;
  bit hold_taken = 0;
  int cycles = 0;
  int stall_mode = 0;

  quadratic_real_root_solver u_top (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .coef_const(coef_const), .coef_linear(coef_linear), .coef_square(coef_square),
    .out_valid(out_valid), .out_stall(out_stall),
    .root_first(root_first), .root_second(root_second),
    .root_count(root_count), .saturated(saturated)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("quadratic_real_root_solver test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (cycles % 97 == 0) stall_mode <= $urandom_range(0, 3);
    if (hold_req && !hold_taken) begin
      hold_taken <= 1;
      hold_cycles <= 400;
      out_stall <= 1;
    end else if (hold_cycles > 0) begin
      out_stall <= 1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      case (stall_mode)
        0: out_stall <= 0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= ((cycles % 5) < 2);
      endcase
    end
  end

  always @(negedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result({root_first, root_second, root_count, saturated});
  end

  task automatic send_item(logic [31:0] c, logic [31:0] b, logic [31:0] a);
    bit ok;
    in_valid <= 1;
    coef_const <= c;
    coef_linear <= b;
    coef_square <= a;
    do begin
      @(negedge clk);
      ok = !in_stall;
      @(posedge clk);
    end while (!ok);
    sb.note_input(c, b, a);
  endtask

  task automatic idle_cycles(int n);
    in_valid <= 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_eps(logic [30:0] v);
    drain();
    cfg_wr_en <= 1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 0;
    sb.eps = v;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_coef();
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0, 1: v = $urandom();
      2: v = $urandom_range(0, 8 << 16) - (4 << 16);
      3: v = 0;
      4: v = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      5: v = $urandom_range(0, 7) - 3;
      default: v = ($urandom_range(0, 20) - 10) << 16;
    endcase
    return v;
  endfunction

  task automatic random_items(int n);
    int left;
    left = n;
    while (left > 0) begin
      for (int k = $urandom_range(1, 20); k > 0 && left > 0; k--) begin
        send_item(pick_coef(), pick_coef(), pick_coef());
        left--;
      end
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 6));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    write_eps(31'd1);
    send_item(0, 0, 0);
    send_item(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_item(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001);
    send_item(32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
    send_item(32'h0001_0000, 32'hfffe_0000, 32'h0001_0000);
    send_item(32'h0005_0000, 32'h0001_0000, 32'h0001_0000);
    send_item(32'hfffa_0000, 32'h0001_0000, 32'h0001_0000);
    send_item(32'hfffa_0000, 32'hffff_0000, 32'h0001_0000);
    send_item(32'h0003_0000, 32'h0002_0000, 0);
    send_item(32'h0003_0000, 0, 0);
    send_item(32'h8000_0000, 32'h0000_0001, 0);
    send_item(32'h0004_0000, 0, 32'hffff_0000);
    send_item(0, 32'h0003_0000, 32'h0001_0000);
    send_item(32'h0000_0001, 32'h7fff_ffff, 32'h8000_0000);
    idle_cycles(3);
    random_items(300);
    hold_req = 1;
    for (int i = 0; i < 200; i++) send_item(pick_coef(), pick_coef(), pick_coef());
    write_eps(31'd0);
    send_item(0, 0, 0);
    send_item(32'h0001_0000, 0, 0);
    send_item(32'h0000_0002, 32'h0000_0003, 0);
    random_items(250);
    write_eps(31'h7fff_ffff);
    send_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_item(32'h0001_0000, 32'h8000_0000, 32'h7fff_ffff);
    random_items(250);
    write_eps(31'd65536);
    random_items(250);
    write_eps(31'($urandom_range(0, 4000)));
    random_items(200);
    write_eps(31'($urandom()));
    random_items(150);
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("quadratic_real_root_solver test passed");
    end else begin
      $display("quadratic_real_root_solver test failed");
    end
    $finish;
  end
endmodule

`default_nettype wire
